[hw/rtl/bb3_pkg.sv]
// Shared constants and types for the 3x3 box blur.
package bb3_pkg;

    // Pixel and coordinate widths of the stream
    localparam int PIXEL_BITS    = 8;
    localparam int ROW_BITS      = 16;
    localparam int COL_OUT_BITS  = 10;
    localparam int DEF_MAX_WIDTH = 1024;

    // Configuration register widths and reset values
    localparam int FW_BITS    = 11;
    localparam int FH_BITS    = 16;
    localparam int PADDR_BITS = 3;
    localparam int PDATA_BITS = 32;
    localparam int REG_IDX_BIT = 2;
    localparam logic [FW_BITS-1:0] FW_RESET = 11'd640;
    localparam logic [FH_BITS-1:0] FH_RESET = 16'd480;

    // Nine-tap sum and divide-by-nine through a reciprocal.
    // floor(s*M / 2^S) == floor(s/9) while s * (9*M - 2^S) < 2^S.
    localparam int SUM_BITS      = PIXEL_BITS + 4;
    localparam int DIV_SHIFT     = SUM_BITS + 3;
    localparam int DIV_MUL       = (2 ** DIV_SHIFT + 8) / 9;
    localparam int DIV_MUL_BITS  = DIV_SHIFT - 2;
    localparam int PROD_BITS     = SUM_BITS + DIV_MUL_BITS;

    // Register indexes
    typedef enum logic {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } t_reg_idx;

    // Result slots an input can produce, in emission order
    localparam logic [2:0] SLOT_A = 3'b001;  // own pixel on row 0, else pixel up-left
    localparam logic [2:0] SLOT_B = 3'b010;  // right border pixel of the row above
    localparam logic [2:0] SLOT_C = 3'b100;  // own pixel on the last row

    // Position of a pixel within the frame
    typedef struct packed {
        logic row0;
        logic row_ge2;
        logic col_ge1;
        logic col_ge2;
        logic col_last;
        logic row_last;
    } t_pos_flags;

endpackage

[hw/rtl/bb3_cfg.sv]
// APB register file holding the frame size, with clamped limits.
module bb3_cfg #(
    parameter int MAX_WIDTH = bb3_pkg::DEF_MAX_WIDTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [bb3_pkg::PADDR_BITS-1:0]     paddr,
    input  logic [bb3_pkg::PDATA_BITS-1:0]     pwdata,
    output logic [bb3_pkg::PDATA_BITS-1:0]     prdata,
    output logic                               pready,
    output logic [$clog2(MAX_WIDTH)-1:0]       o_col_last,
    output logic [bb3_pkg::ROW_BITS-1:0]       o_row_last,
    output logic                               o_restart
);
    import bb3_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);

    logic [FW_BITS-1:0] r_frame_width;
    logic [FH_BITS-1:0] r_frame_height;
    logic               w_wr;
    t_reg_idx           w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = t_reg_idx'(paddr[REG_IDX_BIT]);

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FW_RESET;
            r_frame_height <= FH_RESET;
        end else if (w_wr) begin
            case (w_idx)
                REG_FRAME_WIDTH:  r_frame_width  <= pwdata[FW_BITS-1:0];
                REG_FRAME_HEIGHT: r_frame_height <= pwdata[FH_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Any write starts a new frame
    assign o_restart = w_wr;

    // Read back
    always_comb begin
        case (w_idx)
            REG_FRAME_WIDTH:  prdata = PDATA_BITS'(r_frame_width);
            REG_FRAME_HEIGHT: prdata = PDATA_BITS'(r_frame_height);
            default:          prdata = '0;
        endcase
    end

    // Last column: width saturated to 3..MAX_WIDTH, minus one
    always_comb begin
        if (r_frame_width < FW_BITS'(3)) begin
            o_col_last = CW'(2);
        end else if (32'(r_frame_width) > MAX_WIDTH) begin
            o_col_last = CW'(MAX_WIDTH - 1);
        end else begin
            o_col_last = CW'(r_frame_width - FW_BITS'(1));
        end
    end

    // Last row: height of at least 3, minus one
    assign o_row_last = (r_frame_height < FH_BITS'(3)) ? ROW_BITS'(2)
                                                       : ROW_BITS'(r_frame_height - FH_BITS'(1));

endmodule

[hw/rtl/bb3_window.sv]
// Input register, position counters, line stores, 3x3 window and nine-tap sum.
module bb3_window #(
    parameter int MAX_WIDTH = bb3_pkg::DEF_MAX_WIDTH
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [bb3_pkg::PIXEL_BITS-1:0]       i_pixel,
    input  logic [$clog2(MAX_WIDTH)-1:0]         i_col_last,
    input  logic [bb3_pkg::ROW_BITS-1:0]         i_row_last,
    input  logic                                 i_restart,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [bb3_pkg::SUM_BITS-1:0]         o_sum,
    output logic [bb3_pkg::PIXEL_BITS-1:0]       o_wmid,
    output logic [bb3_pkg::PIXEL_BITS-1:0]       o_mid,
    output logic [bb3_pkg::PIXEL_BITS-1:0]       o_pix,
    output logic [bb3_pkg::ROW_BITS-1:0]         o_row,
    output logic [$clog2(MAX_WIDTH)-1:0]         o_col,
    output bb3_pkg::t_pos_flags                  o_flags
);
    import bb3_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);

    // Line stores, read on request accept, written when the item moves on
    logic [PIXEL_BITS-1:0] mem_older [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] mem_newer [MAX_WIDTH];

    logic [CW-1:0]         r_col_cnt;
    logic [ROW_BITS-1:0]   r_row_cnt;

    logic                  r_s1_valid;
    logic [PIXEL_BITS-1:0] r_s1_pix;
    logic [ROW_BITS-1:0]   r_s1_row;
    logic [CW-1:0]         r_s1_col;
    t_pos_flags            r_s1_flags;
    logic [PIXEL_BITS-1:0] r_top;
    logic [PIXEL_BITS-1:0] r_mid;

    logic [PIXEL_BITS-1:0] r_win [6];

    logic                  r_s2_valid;
    logic [SUM_BITS-1:0]   r_s2_sum;
    logic [PIXEL_BITS-1:0] r_s2_wmid;
    logic [PIXEL_BITS-1:0] r_s2_mid;
    logic [PIXEL_BITS-1:0] r_s2_pix;
    logic [ROW_BITS-1:0]   r_s2_row;
    logic [CW-1:0]         r_s2_col;
    t_pos_flags            r_s2_flags;

    logic                  w_s2_free;
    logic                  w_move;
    logic                  w_accept;
    logic                  w_at_col_last;
    logic [SUM_BITS-1:0]   n_sum;
    t_pos_flags            n_flags;

    assign w_s2_free     = !r_s2_valid || i_ready;
    assign w_move        = r_s1_valid && w_s2_free;
    assign o_ready       = !r_s1_valid || w_s2_free;
    assign w_accept      = i_valid && o_ready;
    assign w_at_col_last = (r_col_cnt == i_col_last);

    // Position of the incoming pixel
    always_comb begin
        n_flags.row0     = (r_row_cnt == '0);
        n_flags.row_ge2  = (r_row_cnt >= ROW_BITS'(2));
        n_flags.col_ge1  = (r_col_cnt != '0);
        n_flags.col_ge2  = (r_col_cnt >= CW'(2));
        n_flags.col_last = w_at_col_last;
        n_flags.row_last = (r_row_cnt == i_row_last);
    end

    // Raster counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_col_cnt <= '0;
            r_row_cnt <= '0;
        end else if (w_accept) begin
            if (w_at_col_last) begin
                r_col_cnt <= '0;
                r_row_cnt <= (r_row_cnt == i_row_last) ? '0 : r_row_cnt + ROW_BITS'(1);
            end else begin
                r_col_cnt <= r_col_cnt + CW'(1);
            end
        end
    end

    // Stage 1 control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    // Stage 1 payload and line store reads
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_pix   <= i_pixel;
            r_s1_row   <= r_row_cnt;
            r_s1_col   <= r_col_cnt;
            r_s1_flags <= n_flags;
            r_top      <= mem_older[r_col_cnt];
            r_mid      <= mem_newer[r_col_cnt];
        end
    end

    // Line store writes: the column shifts up by one row
    always_ff @(posedge i_clk) begin
        if (w_move) begin
            mem_older[r_s1_col] <= r_mid;
            mem_newer[r_s1_col] <= r_s1_pix;
        end
    end

    // Nine-tap sum of the current column and the two to its left
    always_comb begin
        n_sum = SUM_BITS'(r_top) + SUM_BITS'(r_mid) + SUM_BITS'(r_s1_pix);
        for (int k = 0; k < 6; k++) begin
            n_sum = n_sum + SUM_BITS'(r_win[k]);
        end
    end

    // Window columns
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            for (int k = 0; k < 6; k++) begin
                r_win[k] <= '0;
            end
        end else if (w_move) begin
            r_win[3] <= r_win[0];
            r_win[4] <= r_win[1];
            r_win[5] <= r_win[2];
            r_win[0] <= r_top;
            r_win[1] <= r_mid;
            r_win[2] <= r_s1_pix;
        end
    end

    // Stage 2 control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_s2_free) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    // Stage 2 payload
    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_s2_sum   <= n_sum;
            r_s2_wmid  <= r_win[1];
            r_s2_mid   <= r_mid;
            r_s2_pix   <= r_s1_pix;
            r_s2_row   <= r_s1_row;
            r_s2_col   <= r_s1_col;
            r_s2_flags <= r_s1_flags;
        end
    end

    assign o_valid = r_s2_valid;
    assign o_sum   = r_s2_sum;
    assign o_wmid  = r_s2_wmid;
    assign o_mid   = r_s2_mid;
    assign o_pix   = r_s2_pix;
    assign o_row   = r_s2_row;
    assign o_col   = r_s2_col;
    assign o_flags = r_s2_flags;

    // Column counter stays within the row
    a_col_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col_cnt <= i_col_last)
        else $error("column counter beyond last column");

    // Last pixel of the frame wraps both counters
    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && w_at_col_last && (r_row_cnt == i_row_last) && !i_restart
        |=> (r_col_cnt == '0) && (r_row_cnt == '0))
        else $error("counters did not wrap at end of frame");

    // A stalled stage 1 item keeps its position
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !w_s2_free |=> r_s1_valid && $stable(r_s1_col) && $stable(r_s1_row))
        else $error("stage 1 item lost while stalled");

endmodule

[hw/rtl/bb3_emit.sv]
// Divide by nine, result slot sequencing and the output register.
module bb3_emit #(
    parameter int MAX_WIDTH = bb3_pkg::DEF_MAX_WIDTH
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [bb3_pkg::SUM_BITS-1:0]         i_sum,
    input  logic [bb3_pkg::PIXEL_BITS-1:0]       i_wmid,
    input  logic [bb3_pkg::PIXEL_BITS-1:0]       i_mid,
    input  logic [bb3_pkg::PIXEL_BITS-1:0]       i_pix,
    input  logic [bb3_pkg::ROW_BITS-1:0]         i_row,
    input  logic [$clog2(MAX_WIDTH)-1:0]         i_col,
    input  bb3_pkg::t_pos_flags                  i_flags,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [bb3_pkg::PIXEL_BITS-1:0]       o_pixel_out,
    output logic [bb3_pkg::ROW_BITS-1:0]         o_out_row,
    output logic [bb3_pkg::COL_OUT_BITS-1:0]     o_out_col,
    output logic                                 o_run_last,
    output logic                                 o_frame_last
);
    import bb3_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);

    logic [2:0]              r_s3_pend;
    logic [PIXEL_BITS-1:0]   r_s3_a_val;
    logic [PIXEL_BITS-1:0]   r_s3_mid;
    logic [PIXEL_BITS-1:0]   r_s3_pix;
    logic [ROW_BITS-1:0]     r_s3_row;
    logic [CW-1:0]           r_s3_col;
    logic                    r_s3_row0;
    logic                    r_s3_corner;

    logic                    r_o_valid;
    logic [PIXEL_BITS-1:0]   r_o_pix;
    logic [ROW_BITS-1:0]     r_o_row;
    logic [CW-1:0]           r_o_col;
    logic                    r_o_run_last;
    logic                    r_o_frame_last;

    logic [PROD_BITS-1:0]    w_prod;
    logic [PIXEL_BITS-1:0]   w_quo;
    logic [PIXEL_BITS-1:0]   n_a_val;
    logic [2:0]              n_pend;
    logic [2:0]              w_sel;
    logic [2:0]              w_rest;
    logic                    w_out_free;
    logic                    w_emit;
    logic                    w_done;
    logic                    w_s3_free;
    logic                    w_load;
    logic [PIXEL_BITS-1:0]   n_o_pix;
    logic [ROW_BITS-1:0]     n_o_row;
    logic [CW-1:0]           n_o_col;

    // Mean of the window: multiply by the reciprocal of nine
    assign w_prod = PROD_BITS'(i_sum) * PROD_BITS'(DIV_MUL);
    assign w_quo  = PIXEL_BITS'(w_prod >> DIV_SHIFT);

    // First slot value: own pixel on row 0, mean inside, left border passes through
    assign n_a_val = i_flags.row0 ? i_pix : (i_flags.col_ge2 ? w_quo : i_wmid);

    // Which results this input produces
    always_comb begin
        n_pend = '0;
        if (i_flags.row0 || (i_flags.row_ge2 && i_flags.col_ge1)) begin
            n_pend = n_pend | SLOT_A;
        end
        if (i_flags.row_ge2 && i_flags.col_last) begin
            n_pend = n_pend | SLOT_B;
        end
        if (i_flags.row_ge2 && i_flags.row_last) begin
            n_pend = n_pend | SLOT_C;
        end
    end

    // Pick the earliest pending slot
    always_comb begin
        if ((r_s3_pend & SLOT_A) != '0) begin
            w_sel = SLOT_A;
        end else if ((r_s3_pend & SLOT_B) != '0) begin
            w_sel = SLOT_B;
        end else begin
            w_sel = r_s3_pend & SLOT_C;
        end
    end

    assign w_rest     = r_s3_pend & ~w_sel;
    assign w_out_free = !r_o_valid || i_ready;
    assign w_emit     = (r_s3_pend != '0) && w_out_free;
    assign w_done     = w_emit && (w_rest == '0);
    assign w_s3_free  = (r_s3_pend == '0) || w_done;
    assign o_ready    = w_s3_free;
    assign w_load     = i_valid && w_s3_free;

    // Slot sequencer: an input with no results is dropped here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_pend <= '0;
        end else if (w_load) begin
            r_s3_pend <= n_pend;
        end else if (w_emit) begin
            r_s3_pend <= w_rest;
        end else if (w_done) begin
            r_s3_pend <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_s3_a_val  <= n_a_val;
            r_s3_mid    <= i_mid;
            r_s3_pix    <= i_pix;
            r_s3_row    <= i_row;
            r_s3_col    <= i_col;
            r_s3_row0   <= i_flags.row0;
            r_s3_corner <= i_flags.row_last && i_flags.col_last;
        end
    end

    // Value and position of the selected slot
    always_comb begin
        case (w_sel)
            SLOT_A: begin
                n_o_pix = r_s3_a_val;
                n_o_row = r_s3_row0 ? r_s3_row : r_s3_row - ROW_BITS'(1);
                n_o_col = r_s3_row0 ? r_s3_col : r_s3_col - CW'(1);
            end
            SLOT_B: begin
                n_o_pix = r_s3_mid;
                n_o_row = r_s3_row - ROW_BITS'(1);
                n_o_col = r_s3_col;
            end
            SLOT_C: begin
                n_o_pix = r_s3_pix;
                n_o_row = r_s3_row;
                n_o_col = r_s3_col;
            end
            default: begin
                n_o_pix = r_s3_pix;
                n_o_row = r_s3_row;
                n_o_col = r_s3_col;
            end
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_emit) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_o_pix        <= n_o_pix;
            r_o_row        <= n_o_row;
            r_o_col        <= n_o_col;
            r_o_run_last   <= (w_rest == '0);
            r_o_frame_last <= (w_sel == SLOT_C) && r_s3_corner;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_pixel_out  = r_o_pix;
    assign o_out_row    = r_o_row;
    assign o_out_col    = COL_OUT_BITS'(r_o_col);
    assign o_run_last   = r_o_run_last;
    assign o_frame_last = r_o_frame_last;

    // End of frame is always the last result of its input
    a_frame_last_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_o_frame_last |-> r_o_run_last)
        else $error("frame_last without run_last");

    // A new input never overwrites results still pending
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> (r_s3_pend == '0) || w_done)
        else $error("pending results overwritten");

    // Without a load the pending set only shrinks
    a_pend_shrink: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s3_pend != '0) && !w_load |=> (r_s3_pend & ~$past(r_s3_pend)) == '0)
        else $error("pending slot appeared without a load");

endmodule

[hw/rtl/box_blur_3x3.sv]
// Top level of the streaming 3x3 box blur.
//
// Pixels enter in raster order on i_valid/o_ready, one request per pixel.
// Results leave on o_valid/i_ready, each carrying its own row and column,
// since a pixel leaves once its window is complete (one row and one column
// behind the input). Inner pixels become the truncated mean of their 3x3
// neighborhood; first/last row and column pass through unchanged.
// Frame size is set through the APB port (width at 0x0, height at 0x4);
// any register write restarts the frame. Write only while the block is idle.
// A result passes the stage 1, stage 2, slot and output registers.
// Throughput: one request per cycle while each input makes at most one
// result and the receiver does not stall. A pixel in the last column or
// on the last row makes up to three results, one per cycle through the
// single output register when free, holding the input side until done.
// Reset clears the counters, window and pipeline; line stores hold no
// reset value and are filled by the first rows. When the receiver stalls,
// the output holds and the pipeline fills, then o_ready drops.
module box_blur_3x3 #(
    parameter int MAX_WIDTH = bb3_pkg::DEF_MAX_WIDTH
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [bb3_pkg::PADDR_BITS-1:0]       paddr,
    input  logic [bb3_pkg::PDATA_BITS-1:0]       pwdata,
    output logic [bb3_pkg::PDATA_BITS-1:0]       prdata,
    output logic                                 pready,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [bb3_pkg::PIXEL_BITS-1:0]       i_pixel_in,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [bb3_pkg::PIXEL_BITS-1:0]       o_pixel_out,
    output logic [bb3_pkg::ROW_BITS-1:0]         o_out_row,
    output logic [bb3_pkg::COL_OUT_BITS-1:0]     o_out_col,
    output logic                                 o_run_last,
    output logic                                 o_frame_last
);
    import bb3_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);

    logic [CW-1:0]         w_col_last;
    logic [ROW_BITS-1:0]   w_row_last;
    logic                  w_restart;

    logic                  w_s2_valid;
    logic                  w_s2_ready;
    logic [SUM_BITS-1:0]   w_sum;
    logic [PIXEL_BITS-1:0] w_wmid;
    logic [PIXEL_BITS-1:0] w_mid;
    logic [PIXEL_BITS-1:0] w_pix;
    logic [ROW_BITS-1:0]   w_row;
    logic [CW-1:0]         w_col;
    t_pos_flags            w_flags;

    // Frame size registers
    bb3_cfg #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_col_last (w_col_last),
        .o_row_last (w_row_last),
        .o_restart  (w_restart)
    );

    // Line stores, window and sum
    bb3_window #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_pixel    (i_pixel_in),
        .i_col_last (w_col_last),
        .i_row_last (w_row_last),
        .i_restart  (w_restart),
        .o_valid    (w_s2_valid),
        .i_ready    (w_s2_ready),
        .o_sum      (w_sum),
        .o_wmid     (w_wmid),
        .o_mid      (w_mid),
        .o_pix      (w_pix),
        .o_row      (w_row),
        .o_col      (w_col),
        .o_flags    (w_flags)
    );

    // Mean and result sequencing
    bb3_emit #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_s2_valid),
        .o_ready      (w_s2_ready),
        .i_sum        (w_sum),
        .i_wmid       (w_wmid),
        .i_mid        (w_mid),
        .i_pix        (w_pix),
        .i_row        (w_row),
        .i_col        (w_col),
        .i_flags      (w_flags),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_pixel_out  (o_pixel_out),
        .o_out_row    (o_out_row),
        .o_out_col    (o_out_col),
        .o_run_last   (o_run_last),
        .o_frame_last (o_frame_last)
    );

endmodule

[test/bb3_checker.sv]
// Scoreboard for the 3x3 box blur: predicts results from accepted pixels and checks them.
`timescale 1ns / 1ps

module bb3_checker #(
    parameter int MAX_WIDTH = bb3_pkg::DEF_MAX_WIDTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [bb3_pkg::PADDR_BITS-1:0]   paddr,
    input  logic [bb3_pkg::PDATA_BITS-1:0]   pwdata,
    input  logic                             pready,
    input  logic                             i_valid,
    input  logic                             o_ready,
    input  logic [bb3_pkg::PIXEL_BITS-1:0]   i_pixel_in,
    input  logic                             o_valid,
    input  logic                             i_ready,
    input  logic [bb3_pkg::PIXEL_BITS-1:0]   o_pixel_out,
    input  logic [bb3_pkg::ROW_BITS-1:0]     o_out_row,
    input  logic [bb3_pkg::COL_OUT_BITS-1:0] o_out_col,
    input  logic                             o_run_last,
    input  logic                             o_frame_last,
    output int                               o_fail_count,
    output int                               o_pending
);
    import bb3_pkg::*;

    localparam int TAPS = 9;

    // One filtered or passed-through pixel as it leaves the block
    typedef struct packed {
        logic [PIXEL_BITS-1:0]   pixel;
        logic [ROW_BITS-1:0]     row;
        logic [COL_OUT_BITS-1:0] col;
        logic                    run_last;
        logic                    frame_last;
    } t_blur_px;

    t_blur_px                blur_q[$];
    logic [PIXEL_BITS-1:0]   line_older [MAX_WIDTH];
    logic [PIXEL_BITS-1:0]   line_newer [MAX_WIDTH];
    logic [PIXEL_BITS-1:0]   win_cols [6];
    int                      col_pos;
    int                      row_pos;
    logic [FW_BITS-1:0]      width_reg;
    logic [FH_BITS-1:0]      height_reg;
    int                      fails = 0;

    initial begin
        foreach (line_older[i]) begin
            line_older[i] = '0;
            line_newer[i] = '0;
        end
    end

    function automatic t_blur_px blur_px(input logic [PIXEL_BITS-1:0] v, input int r,
                                         input int c);
        t_blur_px e;
        e.pixel      = v;
        e.row        = ROW_BITS'(r);
        e.col        = COL_OUT_BITS'(c);
        e.run_last   = 1'b0;
        e.frame_last = 1'b0;
        return e;
    endfunction

    task automatic restart_frame;
        foreach (win_cols[i]) win_cols[i] = '0;
        col_pos = 0;
        row_pos = 0;
    endtask

    // Window update and emission for one accepted pixel
    task automatic predict_blur(input logic [PIXEL_BITS-1:0] px);
        int                    w;
        int                    h;
        int                    r;
        int                    c;
        int                    sum;
        logic [PIXEL_BITS-1:0] top;
        logic [PIXEL_BITS-1:0] mid;
        t_blur_px              batch[$];
        w = int'(width_reg);
        if (w < 3) w = 3;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        h = int'(height_reg);
        if (h < 3) h = 3;
        if (col_pos >= w) col_pos = 0;
        if (row_pos >= h) row_pos = 0;
        r   = row_pos;
        c   = col_pos;
        top = line_older[c];
        mid = line_newer[c];

        if (r == 0) begin
            batch.push_back(blur_px(px, r, c));
        end else if (r >= 2) begin
            // pixel up-left: mean when inner, else the left border passes through
            if (c >= 2) begin
                sum = int'(top) + int'(mid) + int'(px);
                foreach (win_cols[i]) sum += int'(win_cols[i]);
                batch.push_back(blur_px(PIXEL_BITS'(sum / TAPS), r - 1, c - 1));
            end else if (c == 1) begin
                batch.push_back(blur_px(win_cols[1], r - 1, c - 1));
            end
            if (c == w - 1) batch.push_back(blur_px(mid, r - 1, c));
            if (r == h - 1) batch.push_back(blur_px(px, r, c));
        end
        if (batch.size() > 0) begin
            batch[batch.size()-1].run_last   = 1'b1;
            batch[batch.size()-1].frame_last = (r == h - 1) && (c == w - 1);
        end
        foreach (batch[k]) blur_q.push_back(batch[k]);

        line_older[c] = mid;
        line_newer[c] = px;
        win_cols[3]   = win_cols[0];
        win_cols[4]   = win_cols[1];
        win_cols[5]   = win_cols[2];
        win_cols[0]   = top;
        win_cols[1]   = mid;
        win_cols[2]   = px;

        if (c + 1 >= w) begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
        end
    endtask

    task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got,
                               input t_blur_px exp_px);
        if (want !== got) begin
            fails++;
            $display("%0t: %s of pixel (%0d,%0d): expected %0d, got %0d",
                     $time, what, exp_px.row, exp_px.col, want, got);
        end
    endtask

    // Watch both channels and the register port
    always @(posedge i_clk) begin : watch
        t_blur_px want;
        t_blur_px got;
        if (!i_rst_n) begin
            blur_q.delete();
            width_reg  = FW_RESET;
            height_reg = FH_RESET;
            restart_frame();
        end else begin
            if (o_valid && i_ready) begin
                got = {o_pixel_out, o_out_row, o_out_col, o_run_last, o_frame_last};
                if (blur_q.size() == 0) begin
                    fails++;
                    $display("%0t: expected no result, got pixel %0d at (%0d,%0d)",
                             $time, got.pixel, got.row, got.col);
                end else begin
                    want = blur_q.pop_front();
                    check_field("pixel_out", 32'(want.pixel), 32'(got.pixel), want);
                    check_field("out_row", 32'(want.row), 32'(got.row), want);
                    check_field("out_col", 32'(want.col), 32'(got.col), want);
                    check_field("run_last", 32'(want.run_last), 32'(got.run_last), want);
                    check_field("frame_last", 32'(want.frame_last), 32'(got.frame_last),
                                want);
                end
            end
            // any register write restarts the frame
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[REG_IDX_BIT]))
                    REG_FRAME_WIDTH:  width_reg  = pwdata[FW_BITS-1:0];
                    REG_FRAME_HEIGHT: height_reg = pwdata[FH_BITS-1:0];
                    default: ;
                endcase
                restart_frame();
            end
            if (i_valid && o_ready) predict_blur(i_pixel_in);
        end
        o_pending    <= blur_q.size();
        o_fail_count <= fails;
    end

endmodule

[test/tb_top.sv]
// Testbench top for the 3x3 box blur: clock, reset, frame stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
    import bb3_pkg::*;

    localparam int DRAIN_CYCLES = 12;
    localparam int RANDOM_ITEMS = 210;
    localparam int CALM_ITEMS   = 40;

    logic                    i_clk        = 1'b0;
    logic                    i_rst_n      = 1'b0;
    logic                    psel         = 1'b0;
    logic                    penable      = 1'b0;
    logic                    pwrite       = 1'b0;
    logic [PADDR_BITS-1:0]   paddr        = '0;
    logic [PDATA_BITS-1:0]   pwdata       = '0;
    logic [PDATA_BITS-1:0]   prdata;
    logic                    pready;
    logic                    i_valid      = 1'b0;
    logic                    o_ready;
    logic [PIXEL_BITS-1:0]   i_pixel_in   = '0;
    logic                    o_valid;
    logic                    i_ready      = 1'b0;
    logic [PIXEL_BITS-1:0]   o_pixel_out;
    logic [ROW_BITS-1:0]     o_out_row;
    logic [COL_OUT_BITS-1:0] o_out_col;
    logic                    o_run_last;
    logic                    o_frame_last;

    int   blur_fails;
    int   blur_pending;
    logic quiet      = 1'b0;
    logic calm       = 1'b0;
    int   stall_left = 0;
    int   sent       = 0;

    box_blur_3x3 DUT (.*);

    bb3_checker u_checker (
        .*,
        .o_fail_count(blur_fails),
        .o_pending   (blur_pending)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Receiver: random stall bursts
    always @(posedge i_clk) begin
        if (quiet || calm) begin
            i_ready    <= 1'b1;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            i_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 5) == 0) begin
            i_ready    <= 1'b0;
            stall_left <= $urandom_range(0, 4);
        end else begin
            i_ready <= 1'b1;
        end
    end

    // APB write: setup cycle, access cycle until pready, then back to idle
    task automatic apb_write(input t_reg_idx idx, input logic [PDATA_BITS-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_BITS'(idx) << REG_IDX_BIT;
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // One pixel request, with an optional idle burst ahead of it
    task automatic send_pixel(input logic [PIXEL_BITS-1:0] px);
        if (!(quiet || calm) && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_pixel_in <= px;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // Wait for every expected result, then let pixels with no result drain
    task automatic settle;
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (blur_pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [PIXEL_BITS-1:0] pick_pixel(input int mode);
        case (mode)
            3:       return $urandom_range(0, 1) ? '1 : '0;
            4:       return '1;
            5:       return $urandom_range(0, 1) ? PIXEL_BITS'($urandom_range(0, 3))
                                                 : PIXEL_BITS'($urandom_range(252, 255));
            default: return PIXEL_BITS'($urandom);
        endcase
    endfunction

    initial begin : stimulus
        logic [PIXEL_BITS-1:0] mix [16];
        int raw_w;
        int raw_h;
        int cur_w;
        int cur_h;
        int eff_w;
        int eff_h;
        int npix;
        int mode;
        int which;
        int kind;

        mix = '{8'd0, 8'd255, 8'd1, 8'd128, 8'd255, 8'd0, 8'd255, 8'd0,
                8'd7, 8'd200, 8'd64, 8'd3, 8'h55, 8'hAA, 8'h00, 8'hFF};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Saturated 3x3 frame of full-scale pixels: mean at the maximum
        settle();
        apb_write(REG_FRAME_WIDTH, 32'd0);
        apb_write(REG_FRAME_HEIGHT, 32'd2);
        repeat (9) send_pixel('1);

        // 4x3 frame with mixed extremes: two inner means
        settle();
        apb_write(REG_FRAME_WIDTH, 32'd4);
        apb_write(REG_FRAME_HEIGHT, 32'd3);
        for (int i = 0; i < 12; i++) send_pixel(mix[i]);

        // Widest and tallest setting, first pixels of row zero only
        settle();
        apb_write(REG_FRAME_WIDTH, 32'd2047);
        apb_write(REG_FRAME_HEIGHT, 32'd65535);
        for (int i = 12; i < 16; i++) send_pixel(mix[i]);
        cur_w = 2047;
        cur_h = 65535;

        // Random frame sizes, mostly complete small frames
        while (sent < RANDOM_ITEMS) begin
            kind  = $urandom_range(0, 9);
            raw_w = $urandom_range(3, 9);
            raw_h = $urandom_range(3, 5);
            if (kind == 0) raw_w = $urandom_range(0, 2);
            else if (kind == 1) raw_h = $urandom_range(0, 2);
            else if (kind == 2) raw_w = $urandom_range(0, 1) ? $urandom_range(1025, 2047) : 1024;
            else if (kind == 3) raw_h = $urandom_range(6, 65535);

            settle();
            quiet <= ($urandom_range(0, 3) == 0);
            calm  <= (sent >= RANDOM_ITEMS - CALM_ITEMS);
            which = $urandom_range(0, 3);
            if (which == 0) raw_h = cur_h;
            else if (which == 1) raw_w = cur_w;
            if (which != 1) apb_write(REG_FRAME_WIDTH, PDATA_BITS'(raw_w));
            if (which != 0) apb_write(REG_FRAME_HEIGHT, PDATA_BITS'(raw_h));
            cur_w = raw_w;
            cur_h = raw_h;

            eff_w = (raw_w < 3) ? 3 : ((raw_w > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : raw_w);
            eff_h = (raw_h < 3) ? 3 : raw_h;
            if (eff_w * eff_h > 60) npix = $urandom_range(4, 40);
            else if ($urandom_range(0, 4) == 0) npix = $urandom_range(1, eff_w * eff_h - 1);
            else npix = eff_w * eff_h * $urandom_range(1, 2);
            if (npix > RANDOM_ITEMS - sent) npix = RANDOM_ITEMS - sent;

            mode = $urandom_range(0, 5);
            repeat (npix) begin
                send_pixel(pick_pixel(mode));
                sent++;
            end
        end

        settle();
        if (blur_fails == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Hard limit on run time
    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
